@@ src/vasm_pkg.sv @@
// ----------------------------------------------------------------------------
// vasm_pkg: shared types and constants of the voice allocator and mixer
// Command codes, sequencer state codes and the per-note pan gain tables.
// ----------------------------------------------------------------------------
package vasm_pkg;

  typedef enum logic [1:0] {
    CMD_NOTE_ON     = 2'd0,
    CMD_FRAME_BEGIN = 2'd1,
    CMD_SAMPLE      = 2'd2,
    CMD_FRAME_END   = 2'd3
  } cmd_e;

  localparam int unsigned GainBits = 15;
  localparam int unsigned AccBits  = 20;
  localparam int unsigned PanNotes = 8;

  typedef logic [GainBits-1:0] gain_t;

  function automatic gain_t pan_left(input logic [2:0] n);
    gain_t g;
    case (n)
      3'd0: g = 15'd27939;
      3'd1: g = 15'd26724;
      3'd2: g = 15'd25388;
      3'd3: g = 15'd23937;
      3'd4: g = 15'd22378;
      3'd5: g = 15'd20717;
      3'd6: g = 15'd18962;
      default: g = 15'd17121;
    endcase
    return g;
  endfunction

  function automatic gain_t pan_right(input logic [2:0] n);
    return pan_left(3'd7 - n);
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_WALK,
    ST_MIX,
    ST_ACC,
    ST_END
  } state_e;

endpackage

@@ src/vasm_front.sv @@
// ----------------------------------------------------------------------------
// vasm_front: input stage and command queue
// Accept requests, drop ignorable ones, and hold the rest in a short FIFO.
// ----------------------------------------------------------------------------
module vasm_front import vasm_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  input  logic         keep_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);
  localparam int unsigned PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_q [DEPTH];
  logic [PB-1:0] wp_q, rp_q;
  logic [PB:0]   cnt_q;
  logic push, pop;

  assign ready_o = (cnt_q != (PB+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign push    = valid_i && ready_o && keep_i;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PB'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PB'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PB+1)'(push) - (PB+1)'(pop);
    end
  end
endmodule

@@ src/vasm_back.sv @@
// ----------------------------------------------------------------------------
// vasm_back: voice table sequencer and stereo accumulators
// Execute one queued request at a time, one voice per cycle while the output is not held.
// ----------------------------------------------------------------------------
module vasm_back import vasm_pkg::*; #(
  parameter int unsigned VOICES      = 8,
  parameter int unsigned NOTES       = 8,
  parameter int unsigned ADDR_BITS   = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [2:0]             note_i,
  input  logic [ADDR_BITS-1:0]   base_i,
  input  logic [ADDR_BITS-1:0]   len_i,
  input  logic [2:0]             voice_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic                   kind_o,
  output logic [2:0]             fetch_voice_o,
  output logic [ADDR_BITS-1:0]   fetch_address_o,
  output logic signed [AccBits-1:0] mix_left_o,
  output logic signed [AccBits-1:0] mix_right_o,
  output logic                   last_o
);
  localparam int unsigned VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned PW = SAMPLE_BITS + GainBits + 1;
  localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};

  state_e state_q, state_d;

  logic [VOICES-1:0]    act_q;
  logic [ADDR_BITS-1:0] vbase_q [VOICES];
  logic [ADDR_BITS-1:0] vlen_q  [VOICES];
  logic [ADDR_BITS-1:0] vpos_q  [VOICES];
  logic [63:0]          vstamp_q[VOICES];
  gain_t                vgl_q   [VOICES];
  gain_t                vgr_q   [VOICES];
  logic [63:0]          stamp_q;
  logic signed [AccBits-1:0] accl_q, accr_q;

  // Latched request
  logic [2:0]             note_q;
  logic [ADDR_BITS-1:0]   base_q, len_q;
  logic [VB-1:0]          vsel_q;
  logic signed [SAMPLE_BITS-1:0] val_q;

  // Walk/search
  logic [VB:0]   idx_q;
  logic [VB-1:0] tgt_q;
  logic [63:0]   old_q;
  logic          found_q;

  // Products and output register
  logic signed [PW-1:0] pl_q, pr_q;
  logic       ov_q;
  logic       okind_q, olast_q;
  logic [2:0] ovoice_q;
  logic [ADDR_BITS-1:0] oaddr_q;
  logic signed [AccBits-1:0] ol_q, orr_q;

  logic [VB-1:0] iv;
  logic          has_next;
  logic [VB-1:0] next_idx;
  logic [2:0]    note_c;

  assign iv = idx_q[VB-1:0];

  // Find the next active voice at or after idx_q
  always_comb begin
    has_next = 1'b0;
    next_idx = '0;
    for (int k = VOICES-1; k >= 0; k--) begin
      if (act_q[k] && (VB+1)'(k) >= idx_q) begin
        has_next = 1'b1;
        next_idx = VB'(k);
      end
    end
  end

  assign note_c = ((32'(note_q) >= NOTES) ? 3'(NOTES-1) : note_q);

  function automatic logic signed [AccBits-1:0] sat_add(
    input logic signed [AccBits-1:0] a, input logic signed [PW-1:0] p);
    logic signed [PW:0] r;
    logic signed [PW+1:0] s;
    begin
      r = (PW+1)'(p + PW'(16384)) >>> 15;
      s = (PW+2)'(a) + (PW+2)'(r);
      if (s > (PW+2)'(AccMax)) return AccMax;
      if (s < (PW+2)'(AccMin)) return AccMin;
      return AccBits'(s);
    end
  endfunction

  assign ready_o         = (state_q == ST_IDLE);
  assign valid_o         = ov_q;
  assign kind_o          = okind_q;
  assign fetch_voice_o   = ovoice_q;
  assign fetch_address_o = oaddr_q;
  assign mix_left_o      = ol_q;
  assign mix_right_o     = orr_q;
  assign last_o          = olast_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (valid_i) begin
        case (cmd_e'(cmd_i))
          CMD_NOTE_ON:     state_d = ST_SEARCH;
          CMD_FRAME_BEGIN: state_d = ST_WALK;
          CMD_SAMPLE:      state_d = (32'(voice_i) < VOICES) ? ST_MIX : ST_IDLE;
          default:         state_d = ST_END;
        endcase
      end
      ST_SEARCH: if (idx_q == (VB+1)'(VOICES) || found_q) state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_IDLE;
      ST_WALK:   if (!has_next) state_d = ST_IDLE;
      ST_MIX:    state_d = ST_ACC;
      ST_ACC:    state_d = ST_IDLE;
      ST_END:    if (!ov_q || ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && valid_i) begin
      note_q <= note_i; base_q <= base_i; len_q <= len_i;
      vsel_q <= VB'(voice_i); val_q <= value_i;
    end
    if (state_q == ST_WRITE) begin
      vbase_q[tgt_q]  <= base_q;
      vlen_q[tgt_q]   <= len_q;
      vpos_q[tgt_q]   <= '0;
      vstamp_q[tgt_q] <= stamp_q + 64'd1;
      vgl_q[tgt_q]    <= pan_left(note_c);
      vgr_q[tgt_q]    <= pan_right(note_c);
    end
    if (state_q == ST_WALK && has_next && (!ov_q || ready_i))
      vpos_q[next_idx] <= vpos_q[next_idx] + 1'b1;
    if (state_q == ST_MIX) begin
      pl_q <= PW'(val_q) * $signed({1'b0, vgl_q[vsel_q]});
      pr_q <= PW'(val_q) * $signed({1'b0, vgr_q[vsel_q]});
    end
    if (state_q == ST_SEARCH && !found_q && idx_q != (VB+1)'(VOICES)) begin
      if (!act_q[iv]) begin
        tgt_q <= iv;
      end else if (idx_q == '0 || vstamp_q[iv] < old_q) begin
        tgt_q <= iv; old_q <= vstamp_q[iv];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0; stamp_q <= '0; accl_q <= '0; accr_q <= '0;
      idx_q <= '0; found_q <= 1'b0; ov_q <= 1'b0;
      okind_q <= 1'b0; olast_q <= 1'b0; ovoice_q <= '0; oaddr_q <= '0;
      ol_q <= '0; orr_q <= '0;
    end else begin
      if (ov_q && ready_i) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0; found_q <= 1'b0;
        end
        ST_SEARCH: if (!found_q && idx_q != (VB+1)'(VOICES)) begin
          if (!act_q[iv]) found_q <= 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        ST_WRITE: begin
          act_q[tgt_q] <= 1'b1;
          stamp_q <= stamp_q + 64'd1;
        end
        ST_WALK: if (has_next && (!ov_q || ready_i)) begin
          ov_q     <= 1'b1;
          okind_q  <= 1'b0;
          ovoice_q <= 3'(next_idx);
          oaddr_q  <= vbase_q[next_idx] + vpos_q[next_idx];
          ol_q <= '0; orr_q <= '0;
          // Last when no active voice follows this one
          olast_q  <= ((act_q >> next_idx) >> 1) == '0;
          if (vpos_q[next_idx] + 1'b1 >= vlen_q[next_idx]) act_q[next_idx] <= 1'b0;
          idx_q <= (VB+1)'(next_idx) + 1'b1;
        end
        ST_ACC: begin
          accl_q <= sat_add(accl_q, pl_q);
          accr_q <= sat_add(accr_q, pr_q);
        end
        ST_END: if (!ov_q || ready_i) begin
          ov_q <= 1'b1; okind_q <= 1'b1; olast_q <= 1'b1;
          ovoice_q <= '0; oaddr_q <= '0;
          ol_q <= accl_q; orr_q <= accr_q;
          accl_q <= '0; accr_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ src/voice_allocator_stereo_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// voice_allocator_stereo_mixer_unit: polyphonic voice allocator and mixer
// Top level: input queue feeding the voice sequencer.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are carried out one at a time by the
// voice sequencer. A note-on request is taken, then a search scans one voice
// a cycle for a free or the oldest voice, then the voice is written; frame
// begin walks the active voices, with one fetch request leaving per cycle
// while the output is taken; a sample request is taken, multiplied by the
// gains, then rounded and added with saturation; frame end waits for the
// output register and sends the mix. The voice scan sets the rate. Note-on
// requests with zero length are dropped at the queue input; samples for
// voices beyond range are dropped by the sequencer. Results leave through an
// output register.
module voice_allocator_stereo_mixer_unit import vasm_pkg::*; #(
  parameter int unsigned VOICES      = 8,
  parameter int unsigned NOTES       = 8,
  parameter int unsigned ADDR_BITS   = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [2:0]             note_index_i,
  input  logic [ADDR_BITS-1:0]   sample_base_i,
  input  logic [ADDR_BITS-1:0]   sample_length_i,
  input  logic [2:0]             sample_voice_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [2:0]             fetch_voice_o,
  output logic [ADDR_BITS-1:0]   fetch_address_o,
  output logic signed [AccBits-1:0] mix_left_o,
  output logic signed [AccBits-1:0] mix_right_o,
  output logic                   last_o
);
  localparam int unsigned W = 2 + 3 + 2*ADDR_BITS + 3 + SAMPLE_BITS;

  logic [W-1:0] qd, qo;
  logic keep, qv, qr;

  assign qd = {cmd_i, note_index_i, sample_base_i, sample_length_i,
               sample_voice_i, sample_value_i};
  // Drop zero-length note-ons at the door
  assign keep = !((cmd_e'(cmd_i) == CMD_NOTE_ON) && (sample_length_i == '0));

  vasm_front #(.W(W), .DEPTH(2)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o), .data_i(qd),
    .keep_i(keep), .valid_o(qv), .ready_i(qr), .data_o(qo)
  );

  vasm_back #(.VOICES(VOICES), .NOTES(NOTES), .ADDR_BITS(ADDR_BITS),
              .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(qv), .ready_o(qr),
    .cmd_i(qo[W-1 -: 2]),
    .note_i(qo[W-3 -: 3]),
    .base_i(qo[W-6 -: ADDR_BITS]),
    .len_i(qo[W-6-ADDR_BITS -: ADDR_BITS]),
    .voice_i(qo[SAMPLE_BITS+2 -: 3]),
    .value_i(qo[SAMPLE_BITS-1:0]),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .kind_o, .fetch_voice_o, .fetch_address_o, .mix_left_o, .mix_right_o, .last_o
  );
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: voice allocator and stereo mixer check
// Drives note-on, frame, sample and frame-end requests with random gaps and
// output stalls, predicts fetch and mix results and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import vasm_pkg::*;

  localparam int NV = 8;

  typedef struct packed {
    logic               kind;
    logic [2:0]         voice;
    logic [23:0]        addr;
    logic signed [19:0] left;
    logic signed [19:0] right;
    logic               last;
  } mix_res_t;

  typedef struct {
    cmd_e               cmd;
    logic [2:0]         note;
    logic [23:0]        base;
    logic [23:0]        len;
    logic [2:0]         voice;
    logic signed [15:0] value;
    bit                 typed;
    logic signed [19:0] exp_left;
    logic signed [19:0] exp_right;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_FRAME_END;
  logic [2:0] note_index_i = '0;
  logic [23:0] sample_base_i = '0;
  logic [23:0] sample_length_i = '0;
  logic [2:0] sample_voice_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic kind_o;
  logic [2:0] fetch_voice_o;
  logic [23:0] fetch_address_o;
  logic signed [19:0] mix_left_o, mix_right_o;
  logic last_o;

  voice_allocator_stereo_mixer_unit u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow voice state.
  bit          v_active [NV];
  bit          v_started[NV];
  logic [23:0] v_base   [NV];
  logic [23:0] v_len    [NV];
  logic [23:0] v_pos    [NV];
  logic [63:0] v_stamp  [NV];
  logic [14:0] v_gl     [NV];
  logic [14:0] v_gr     [NV];
  logic [63:0] stamp_ctr = '0;
  longint      acc_l = 0, acc_r = 0;

  mix_res_t expected_q[$];
  int       n_mismatch = 0;
  bit       quiet_phase = 1'b0;

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  function automatic logic [14:0] pan_gain(input logic [2:0] n, input bit right);
    logic [14:0] t [8] = '{27939, 26724, 25388, 23937, 22378, 20717, 18962, 17121};
    return right ? t[3'd7 - n] : t[n];
  endfunction

  function automatic longint round_mix(input longint s, input longint g, input longint acc);
    longint q;
    q = ((s * g + 16384) >>> 15) + acc;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q;
  endfunction

  // Advance the shadow state by one request and queue its results.
  task automatic predict_mix(input req_t r);
    int tgt;
    bit found;
    mix_res_t e;
    int first;
    found = 0;
    tgt = 0;
    first = expected_q.size();
    case (r.cmd)
      CMD_NOTE_ON: if (r.len != 0) begin
        for (int i = 0; i < NV; i++)
          if (!found && !v_active[i]) begin
            tgt = i;
            found = 1;
          end
        if (!found)
          for (int i = 1; i < NV; i++)
            if (v_stamp[i] < v_stamp[tgt]) tgt = i;
        stamp_ctr++;
        v_active[tgt] = 1;
        v_started[tgt] = 1;
        v_base[tgt] = r.base;
        v_len[tgt] = r.len;
        v_pos[tgt] = '0;
        v_stamp[tgt] = stamp_ctr;
        v_gl[tgt] = pan_gain(r.note, 0);
        v_gr[tgt] = pan_gain(r.note, 1);
      end
      CMD_FRAME_BEGIN: begin
        for (int i = 0; i < NV; i++)
          if (v_active[i]) begin
            e = '0;
            e.voice = 3'(i);
            e.addr = v_base[i] + v_pos[i];
            expected_q.push_back(e);
            v_pos[i] = v_pos[i] + 24'd1;
            if (v_pos[i] >= v_len[i]) v_active[i] = 0;
          end
        if (expected_q.size() > first) expected_q[$].last = 1'b1;
      end
      CMD_SAMPLE: begin
        acc_l = round_mix(r.value, v_gl[r.voice], acc_l);
        acc_r = round_mix(r.value, v_gr[r.voice], acc_r);
      end
      default: begin
        e = '0;
        e.kind = 1'b1;
        e.left = 20'(acc_l);
        e.right = 20'(acc_r);
        e.last = 1'b1;
        if (r.typed) begin
          e.left = r.exp_left;
          e.right = r.exp_right;
        end
        expected_q.push_back(e);
        acc_l = 0;
        acc_r = 0;
      end
    endcase
  endtask

  // Output side: stall a random number of cycles per result, check on accept.
  int stall_left = 0;
  always @(posedge clk_i) begin
    mix_res_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, kind", kind_o, 0);
      end else begin
        e = expected_q.pop_front();
        if (kind_o !== e.kind) report("kind", kind_o, e.kind);
        if (fetch_voice_o !== e.voice) report("fetch_voice", fetch_voice_o, e.voice);
        if (fetch_address_o !== e.addr) report("fetch_address", fetch_address_o, e.addr);
        if (mix_left_o !== e.left) report("mix_left", mix_left_o, e.left);
        if (mix_right_o !== e.right) report("mix_right", mix_right_o, e.right);
        if (last_o !== e.last) report("last", last_o, e.last);
      end
      stall_left = quiet_phase ? 0 : $urandom_range(0, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  req_t dir_tab[$];
  req_t pending[$];

  function automatic req_t mk(input cmd_e c, input logic [2:0] n, input logic [23:0] b,
                              input logic [23:0] l, input logic [2:0] v,
                              input logic signed [15:0] s);
    req_t r;
    r.cmd = c; r.note = n; r.base = b; r.len = l; r.voice = v; r.value = s;
    r.typed = 0; r.exp_left = '0; r.exp_right = '0;
    return r;
  endfunction

  function automatic logic [2:0] any_started();
    int pick;
    do pick = $urandom_range(0, NV - 1); while (!v_started[pick]);
    return 3'(pick);
  endfunction

  // Send one request: hold valid until accepted, keep it high into a zero gap.
  task automatic send_req(input req_t r);
    cmd_i <= r.cmd;
    note_index_i <= r.note;
    sample_base_i <= r.base;
    sample_length_i <= r.len;
    sample_voice_i <= r.voice;
    sample_value_i <= r.value;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_mix(r);
  endtask

  task automatic gap_then_send(input req_t r);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_req(r);
  endtask

  initial begin
    req_t r;
    int n_items;
    int n_notes;
    foreach (v_active[i]) begin
      v_active[i] = 0; v_started[i] = 0; v_stamp[i] = '0;
      v_gl[i] = '0; v_gr[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty frame end after reset, empty frame begin,
    // ignored zero length, every note, address wrap, stealing, full-scale samples.
    r = mk(CMD_FRAME_END, 0, 0, 0, 0, 0);
    r.typed = 1;
    dir_tab.push_back(r);
    dir_tab.push_back(mk(CMD_FRAME_BEGIN, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(CMD_NOTE_ON, 3, 24'h123456, 24'd0, 0, 0));
    dir_tab.push_back(mk(CMD_NOTE_ON, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    for (int n = 1; n < 8; n++)
      dir_tab.push_back(mk(CMD_NOTE_ON, 3'(n), 24'(24'h000100 * n), 24'd2, 0, 0));
    dir_tab.push_back(mk(CMD_NOTE_ON, 7, 24'h000000, 24'd1, 0, 0));
    dir_tab.push_back(mk(CMD_FRAME_BEGIN, 0, 0, 0, 0, 0));
    for (int v = 0; v < 5; v++)
      dir_tab.push_back(mk(CMD_SAMPLE, 0, 0, 0, 3'(v), 16'sh7FFF));
    dir_tab.push_back(mk(CMD_FRAME_END, 0, 0, 0, 0, 0));
    for (int v = 0; v < 5; v++)
      dir_tab.push_back(mk(CMD_SAMPLE, 0, 0, 0, 3'(v), -16'sd32768));
    dir_tab.push_back(mk(CMD_FRAME_END, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(CMD_FRAME_BEGIN, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) gap_then_send(dir_tab[i]);

    // Random frames: note-ons, frame begin, samples for fetched and started voices, usually an end.
    n_items = 0;
    while (n_items < 70) begin
      if ($urandom_range(0, 3) == 0) quiet_phase = !quiet_phase;
      n_notes = $urandom_range(0, 3);
      for (int k = 0; k < n_notes; k++) begin
        r = mk(CMD_NOTE_ON, 3'($urandom_range(0, 7)), 24'($urandom),
               ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6)),
               0, 0);
        gap_then_send(r);
        n_items++;
      end
      for (int i = 0; i < NV; i++)
        if (v_active[i]) pending.push_back(mk(CMD_SAMPLE, 0, 0, 0, 3'(i), 0));
      gap_then_send(mk(CMD_FRAME_BEGIN, 0, 0, 0, 0, 0));
      n_items++;
      if ($urandom_range(0, 3) == 0 && v_started.sum() with (int'(item)) != 0)
        pending.push_back(mk(CMD_SAMPLE, 0, 0, 0, any_started(), 0));
      while (pending.size() > 0) begin
        r = pending.pop_front();
        case ($urandom_range(0, 7))
          0: r.value = 16'sh7FFF;
          1: r.value = -16'sd32768;
          default: r.value = 16'($urandom);
        endcase
        gap_then_send(r);
        n_items++;
      end
      if ($urandom_range(0, 5) != 0) begin
        gap_then_send(mk(CMD_FRAME_END, 0, 0, 0, 0, 0));
        n_items++;
      end
    end
    gap_then_send(mk(CMD_FRAME_END, 0, 0, 0, 0, 0));
    in_valid_i <= 1'b0;

    // Drain, then allow the sequencer a little slack.
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
